@@ sv/screen_fade_alpha_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Screen fade alpha controller: assertion macros
// Concurrent checks sampled on aclk, gated off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SCREEN_FADE_ALPHA_CONTROLLER_DEFINES_SVH
`define SCREEN_FADE_ALPHA_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define SFAC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sfac assertion failed");

// Next-cycle implication.
`define SFAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sfac assertion failed");

`endif

@@ sv/sfac_pkg.sv @@
// ----------------------------------------------------------------------------
// sfac_pkg
// Shared types and constants of the screen fade alpha controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sfac_pkg;

    localparam int unsigned CNT_W   = 15;
    localparam int unsigned ALPHA_W = 8;
    localparam int unsigned DLY_W   = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;
    localparam logic [CNT_W-1:0]   CNT_MAX    = 15'h7FFF;

    typedef enum logic [1:0] {
        MODE_OPAQUE   = 2'd0,
        MODE_CLEAR    = 2'd1,
        MODE_FADE_IN  = 2'd2,
        MODE_FADE_OUT = 2'd3
    } fade_mode_t;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_FADE_IN  = 2'd1,
        ACT_FADE_OUT = 2'd2,
        ACT_STATUS   = 2'd3
    } action_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

@@ sv/sfac_div.sv @@
// ----------------------------------------------------------------------------
// sfac_div
// Serial restoring divider: (count*255)/length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfac_div
    import sfac_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [CNT_W-1:0]   count,    // must be below length
    input  wire logic [CNT_W-1:0]   length,
    output logic [ALPHA_W-1:0]      quotient,
    output div_status_t             status
);

    // quotient fits in 8 bits since count < length
    logic [CNT_W+ALPHA_W-1:0] prod;
    logic [CNT_W+1:0]         diff;
    logic                     ge;

    logic [CNT_W-1:0]   rem_reg,  rem_next;
    logic [ALPHA_W-1:0] low_reg,  low_next;
    logic [CNT_W-1:0]   dvs_reg;
    logic [2:0]         step_reg;
    logic               busy_reg;
    logic               done_reg;

    assign prod = {count, {ALPHA_W{1'b0}}} - {{ALPHA_W{1'b0}}, count};
    assign diff = {1'b0, rem_reg, low_reg[ALPHA_W-1]} - {2'b00, dvs_reg};
    assign ge   = ~diff[CNT_W+1];

    always_comb begin
        rem_next = ge ? diff[CNT_W-1:0] : {rem_reg[CNT_W-2:0], low_reg[ALPHA_W-1]};
        low_next = {low_reg[ALPHA_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= prod[CNT_W+ALPHA_W-1:ALPHA_W];
                low_reg  <= prod[ALPHA_W-1:0];
                dvs_reg  <= length;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                low_reg  <= low_next;
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = low_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

@@ sv/screen_fade_alpha_controller.sv @@
// A word that needs no ramp division gives its result in the cycle after acceptance.
// A frame tick that does not end a running fade divides count*255 by the fade length in the
// serial divider, 8 steps, and gives its result once the divider reports done.
// A new word is accepted only after the result of the last one has been taken.
// Reset (aresetn low, synchronous): mode opaque, alpha 255, no delayed change pending.
// ----------------------------------------------------------------------------
// screen_fade_alpha_controller
// Overlay fade sequencer: steady/fading modes, delayed status, alpha ramp.
// ----------------------------------------------------------------------------
`default_nettype none
`include "screen_fade_alpha_controller_defines.svh"

module screen_fade_alpha_controller
    import sfac_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input word
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [14:0] duration, [15] target_clear, [31:16] delay
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    // result word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [7:0] alpha, [8] drawn, [10:9] mode,
                                        // [11] accepted, [15:12] zero
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;

    // architectural state
    fade_mode_t         mode_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   len_reg;
    logic               pend_reg;
    logic [DLY_W:0]     dc_reg;      // signed countdown, all ones = nothing pending
    logic [ALPHA_W-1:0] alpha_reg;
    // result flags
    logic               drawn_reg;
    logic               acc_reg;

    // input fields
    action_t            action;
    logic [CNT_W-1:0]   duration;
    logic               target_clear;
    logic [DLY_W-1:0]   delay;
    logic               accept;

    // tick evaluation on the current state
    fade_mode_t         tk_mode;     // mode after delayed change
    logic [DLY_W:0]     tk_dc;
    logic [CNT_W-1:0]   tk_cnt;
    logic               tk_done;     // fade reaches its length this tick
    logic               tk_div;      // needs the ramp division

    logic               div_start;
    logic [ALPHA_W-1:0] div_q;
    div_status_t        div_stat;
    logic [ALPHA_W-1:0] ramp_alpha;

    assign action       = action_t'(s_tuser);
    assign duration     = s_tdata[14:0];
    assign target_clear = s_tdata[15];
    assign delay        = s_tdata[31:16];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        tk_mode = mode_reg;
        tk_dc   = dc_reg;
        if (!dc_reg[DLY_W]) begin
            if (dc_reg == '0) begin
                tk_mode = fade_mode_t'({1'b0, pend_reg});
            end
            tk_dc = dc_reg - 1'b1;
        end
        tk_cnt  = (cnt_reg < CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
        // length zero lands here too: count >= 0 always
        tk_done = (tk_cnt >= len_reg);
        tk_div  = tk_mode[1] && !tk_done;
    end

    assign div_start = accept && (action == ACT_TICK) && tk_div;

    sfac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .count    (tk_cnt),
        .length   (len_reg),
        .quotient (div_q),
        .status   (div_stat)
    );

    // fading in runs the ramp downward
    assign ramp_alpha = (mode_reg == MODE_FADE_IN) ? ALPHA_FULL - div_q : div_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_OPAQUE;
            cnt_reg   <= '0;
            len_reg   <= '0;
            pend_reg  <= 1'b0;
            dc_reg    <= '1;
            alpha_reg <= ALPHA_FULL;
            drawn_reg <= 1'b0;
            acc_reg   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        drawn_reg <= 1'b0;
                        acc_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                        case (action)
                            ACT_TICK: begin
                                dc_reg   <= tk_dc;
                                mode_reg <= tk_mode;
                                case (tk_mode)
                                    MODE_CLEAR: begin
                                        drawn_reg <= 1'b0;
                                    end
                                    MODE_OPAQUE: begin
                                        alpha_reg <= ALPHA_FULL;
                                        drawn_reg <= 1'b1;
                                    end
                                    default: begin
                                        cnt_reg <= tk_cnt;
                                        if (tk_done) begin
                                            // fade in ends clear at 0, fade out opaque at 255
                                            if (tk_mode == MODE_FADE_IN) begin
                                                alpha_reg <= '0;
                                                drawn_reg <= 1'b0;
                                                mode_reg  <= MODE_CLEAR;
                                            end else begin
                                                alpha_reg <= ALPHA_FULL;
                                                drawn_reg <= 1'b1;
                                                mode_reg  <= MODE_OPAQUE;
                                            end
                                        end else begin
                                            state_reg <= ST_DIV;
                                        end
                                    end
                                endcase
                            end
                            ACT_FADE_IN: begin
                                if (mode_reg == MODE_OPAQUE) begin
                                    mode_reg <= MODE_FADE_IN;
                                    cnt_reg  <= '0;
                                    len_reg  <= duration;
                                    acc_reg  <= 1'b1;
                                end
                            end
                            ACT_FADE_OUT: begin
                                if (mode_reg == MODE_CLEAR) begin
                                    mode_reg <= MODE_FADE_OUT;
                                    cnt_reg  <= '0;
                                    len_reg  <= duration;
                                    acc_reg  <= 1'b1;
                                end
                            end
                            default: begin
                                pend_reg <= target_clear;
                                if (delay != '0) begin
                                    dc_reg <= {1'b0, delay};
                                end else begin
                                    mode_reg <= fade_mode_t'({1'b0, target_clear});
                                    dc_reg   <= '0;
                                end
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        alpha_reg <= ramp_alpha;
                        drawn_reg <= (ramp_alpha != '0);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {4'b0000, acc_reg, mode_reg, drawn_reg, alpha_reg};

    // input and output sides never open together
    `SFAC_ASSERT_IMPLIES(a_one_side, s_tready, !m_tvalid)
    // divider finishes only while the sequencer waits for it
    `SFAC_ASSERT_IMPLIES(a_div_done_in_div, div_stat.done, state_reg == ST_DIV)
    // a ramp tick leaves the divider running
    `SFAC_ASSERT_NEXT(a_div_started, div_start, div_stat.busy && state_reg == ST_DIV)
    // an accepted start always reports a fading mode
    `SFAC_ASSERT_IMPLIES(a_acc_fading, m_tvalid && m_tdata[11], m_tdata[10])
    // a drawn box is never fully transparent
    `SFAC_ASSERT_IMPLIES(a_drawn_alpha, m_tvalid && m_tdata[8], m_tdata[7:0] != 8'd0)

endmodule

`default_nettype wire
